// ===== design/lesf_pkg.sv =====
// Shared types and constants of the largest empty square finder.
// Depends on nothing; imported by every module of the block but lesf_ram.
`default_nettype none

package lesf_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 4096;

    localparam int COL_W  = $clog2(MAX_COLUMNS);      // column index
    localparam int RUN_W  = $clog2(MAX_COLUMNS + 1);  // run length, also column count
    localparam int ROW_W  = $clog2(MAX_ROWS);         // row index
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);     // row count

    localparam int CODE_W      = 8;
    localparam int CFG_COLS_W  = 11;
    localparam int CFG_ROWS_W  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_CODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLUMNS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS     = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]     empty_code;
        logic [CODE_W-1:0]     obstacle_code;
        logic [CFG_COLS_W-1:0] grid_columns;
        logic [CFG_ROWS_W-1:0] grid_rows;
    } cfg_t;

    // one classified cell, handed from the scan stage to the update stage
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             obstacle;
        logic             bad;        // invalid code or misplaced line end
        logic             last_cell;
    } cell_info_t;

    typedef struct packed {
        logic [RUN_W-1:0] side_len;
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] left_column;
        logic             map_error;
    } result_t;

endpackage

`default_nettype wire

// ===== design/lesf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; read returns the old word when read and write hit one address.
`default_nettype none

module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lesf_scan.sv =====
// Scan stage: column/row position counters and cell classification.
// Depends on lesf_pkg.
`default_nettype none

module lesf_scan
    import lesf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              accept,
    input  wire logic [CODE_W-1:0] cell_code,
    input  wire logic              row_end,
    output cell_info_t             info
);

    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [RUN_W-1:0]  cols;
    logic [ROWS_W-1:0] rows;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic              last_col;
    logic              last_cell;
    logic              is_empty;
    logic              is_obst;

    // out-of-range sizes clamp to 1 .. max
    always_comb begin
        if (cfg.grid_columns == '0) begin
            cols = RUN_W'(1);
        end else if (RUN_W'(cfg.grid_columns) > RUN_W'(MAX_COLUMNS)) begin
            cols = RUN_W'(MAX_COLUMNS);
        end else begin
            cols = RUN_W'(cfg.grid_columns);
        end
        if (cfg.grid_rows == '0) begin
            rows = ROWS_W'(1);
        end else if (ROWS_W'(cfg.grid_rows) > ROWS_W'(MAX_ROWS)) begin
            rows = ROWS_W'(MAX_ROWS);
        end else begin
            rows = ROWS_W'(cfg.grid_rows);
        end
    end

    always_comb begin
        c = ({1'b0, col_cnt_reg} >= cols) ? '0 : col_cnt_reg;
        r = ({1'b0, row_cnt_reg} >= rows) ? ROW_W'(rows - ROWS_W'(1)) : row_cnt_reg;
        last_col  = ({1'b0, c} == cols - RUN_W'(1));
        last_cell = last_col && ({1'b0, r} == rows - ROWS_W'(1));

        // equal codes: obstacle wins
        is_obst  = (cell_code == cfg.obstacle_code);
        is_empty = !is_obst && (cell_code == cfg.empty_code);

        info.col       = c;
        info.row       = r;
        info.obstacle  = !is_empty;
        info.bad       = (!is_obst && !is_empty)
                       || ((row_end != last_col) && !(last_cell && !row_end));
        info.last_cell = last_cell;
    end

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            priority if (last_cell) begin
                col_cnt_next = '0;
                row_cnt_next = '0;
            end else if (last_col) begin
                col_cnt_next = '0;
                row_cnt_next = r + ROW_W'(1);
            end else begin
                col_cnt_next = c + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lesf_update.sv =====
// Update stage: square-run recurrence, line buffer write-back with forwarding,
// best square tracking and the result register. Depends on lesf_pkg.
`default_nettype none

module lesf_update
    import lesf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire cell_info_t       info,
    output logic                  take,
    input  wire logic [RUN_W-1:0] line_rd_data,
    output logic                  line_wr_en,
    output logic      [COL_W-1:0] line_wr_addr,
    output logic      [RUN_W-1:0] line_wr_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res
);

    logic             p1_valid_reg, p1_valid_next;
    cell_info_t       p1_info_reg;
    logic             fwd_valid_reg;
    logic [COL_W-1:0] fwd_addr_reg;
    logic [RUN_W-1:0] fwd_data_reg;
    logic [RUN_W-1:0] left_run_reg;
    logic [RUN_W-1:0] diag_run_reg;
    logic [RUN_W-1:0] best_size_reg, best_size_next;
    logic [ROW_W-1:0] best_top_reg, best_top_next;
    logic [COL_W-1:0] best_left_reg, best_left_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;

    logic             advance;
    logic [RUN_W-1:0] up_raw, up, left, diag, m, run;

    assign advance = p1_valid_reg
                   && (!p1_info_reg.last_cell || !out_valid_reg || res_ready);
    assign take    = !p1_valid_reg || advance;

    always_comb begin
        p1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : p1_valid_reg);
    end

    // latest write wins over the RAM word read in the same cycle
    always_comb begin
        up_raw = (fwd_valid_reg && fwd_addr_reg == p1_info_reg.col) ? fwd_data_reg
                                                                    : line_rd_data;
        up   = (p1_info_reg.row == '0) ? '0 : up_raw;
        left = (p1_info_reg.col == '0) ? '0 : left_run_reg;
        diag = (p1_info_reg.row == '0 || p1_info_reg.col == '0) ? '0 : diag_run_reg;
        m    = (up < left) ? up : left;
        m    = (m < diag) ? m : diag;
        run  = p1_info_reg.obstacle ? '0 : m + RUN_W'(1);
    end

    assign line_wr_en   = advance;
    assign line_wr_addr = p1_info_reg.col;
    assign line_wr_data = run;

    always_comb begin
        best_size_next = best_size_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        err_next       = err_reg | p1_info_reg.bad;
        if (run > best_size_reg) begin
            best_size_next = run;
            best_top_next  = ROW_W'({1'b0, p1_info_reg.row} + (ROW_W+1)'(1)
                                    - (ROW_W+1)'(run));
            best_left_next = COL_W'({1'b0, p1_info_reg.col} + (COL_W+1)'(1)
                                    - (COL_W+1)'(run));
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !res_ready;
        if (advance && p1_info_reg.last_cell) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                fwd_valid_reg <= 1'b1;
                if (p1_info_reg.last_cell) begin
                    best_size_reg <= '0;
                    best_top_reg  <= '0;
                    best_left_reg <= '0;
                    err_reg       <= 1'b0;
                end else begin
                    best_size_reg <= best_size_next;
                    best_top_reg  <= best_top_next;
                    best_left_reg <= best_left_next;
                    err_reg       <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_info_reg <= info;
        end
        if (advance) begin
            fwd_addr_reg <= p1_info_reg.col;
            fwd_data_reg <= run;
            left_run_reg <= run;
            diag_run_reg <= up;
            if (p1_info_reg.last_cell) begin
                if (err_next) begin
                    out_reg <= '{side_len: '0, top_row: '0, left_column: '0,
                                 map_error: 1'b1};
                end else begin
                    out_reg <= '{side_len: best_size_next, top_row: best_top_next,
                                 left_column: best_left_next, map_error: 1'b0};
                end
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// ===== design/largest_empty_square_finder.sv =====
// Top level of the largest empty square finder: configuration registers,
// scan stage, line buffer RAM and update stage. Depends on lesf_pkg, lesf_ram,
// lesf_scan and lesf_update.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tdata = cell_code, s_tlast = row_end
//  m_      | out | m_tvalid / m_tready    | m_tdata = size/top/left, m_tuser = error
//  cfg_    | in  | cfg_we (no handshake)  | cfg_index selects register, cfg_wdata
//
// One cell per cycle while results are claimed on m_. A cell is classified
// and its line buffer entry read in the cycle it is accepted; the update
// stage computes the run from its registered copy, writes the entry back
// and updates the best square as the cell advances. Back-to-back cells on
// the same column (one-column grids) are served from a forwarding register.
// The result register and m_tvalid both load as the last cell of a grid
// leaves the update stage, which holds it while the previous result waits.
// Reset (synchronous, aresetn low) clears counters, best square and valids;
// the line buffer needs no clearing since row 0 never reads it.
// Input stalls only when a last cell is ready and the previous result is
// still unclaimed on m_.
`default_nettype none

module largest_empty_square_finder
    import lesf_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input cells
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] cell_code
    input  wire logic                   s_tlast,   // row_end
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [39:0]            m_tdata,   // [10:0] side_len, [22:11] top_row,
                                                   // [32:23] left_column, [39:33] zero
    output logic                        m_tuser,   // map_error
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t             cfg_reg;
    cell_info_t       info;
    logic             accept;
    logic             take;
    logic [RUN_W-1:0] line_rd_data;
    logic             line_wr_en;
    logic [COL_W-1:0] line_wr_addr;
    logic [RUN_W-1:0] line_wr_data;
    result_t          res;

    // ---- configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.empty_code    <= CODE_W'(46);
            cfg_reg.obstacle_code <= CODE_W'(111);
            cfg_reg.grid_columns  <= CFG_COLS_W'(1);
            cfg_reg.grid_rows     <= CFG_ROWS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EMPTY_CODE:    cfg_reg.empty_code    <= cfg_wdata[CODE_W-1:0];
                REG_OBSTACLE_CODE: cfg_reg.obstacle_code <= cfg_wdata[CODE_W-1:0];
                REG_GRID_COLUMNS:  cfg_reg.grid_columns  <= cfg_wdata[CFG_COLS_W-1:0];
                REG_GRID_ROWS:     cfg_reg.grid_rows     <= cfg_wdata[CFG_ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = take;
    assign accept   = s_tvalid && take;

    // ---- scan: position and classification
    lesf_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .accept    (accept),
        .cell_code (s_tdata),
        .row_end   (s_tlast),
        .info      (info)
    );

    // ---- line buffer: run length of the row above, one entry per column
    lesf_ram #(
        .WIDTH (RUN_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data),
        .rd_en   (accept),
        .rd_addr (info.col),
        .rd_data (line_rd_data)
    );

    // ---- update: recurrence, best square, result register
    lesf_update u_update (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .info         (info),
        .take         (take),
        .line_rd_data (line_rd_data),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (res)
    );

    assign m_tdata = {7'd0, res.left_column, res.top_row, res.side_len};
    assign m_tuser = res.map_error;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for largest_empty_square_finder: streams grids of cells,
// predicts each grid's largest empty square and checks the block's results.
// Depends on lesf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
    import lesf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 5000;  // cycles without any item moving
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_CELLS  = 1050;
    localparam int RANDOM_GRIDS  = 40;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              row_end;
    } cell_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    logic [7:0]             s_tdata   = '0;   // [7:0] cell_code
    logic                   s_tlast   = 1'b0; // row_end
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    wire  [39:0]            m_tdata;          // [10:0] size, [22:11] top, [32:23] left
    wire                    m_tuser;          // map_error
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_EMPTY_CODE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    largest_empty_square_finder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Stimulus and scoreboard storage
    cell_t   cell_queue[$];        // cells waiting for the sender
    result_t pending_squares[$];   // predicted results, oldest first
    int      cells_out   = 0;      // cells put on the bus by the sender
    int      cells_in    = 0;      // cells accepted by the block
    int      mismatches  = 0;
    int      idle_cycles = 0;

    // Receiver long hold: the stimulus bumps the request count
    int      hold_requests = 0;
    int      hold_served   = 0;

    // Register shadow, as the block holds it
    logic [CODE_W-1:0]     empty_sel    = 8'd46;
    logic [CODE_W-1:0]     obstacle_sel = 8'd111;
    logic [CFG_COLS_W-1:0] cols_sel     = 11'd1;
    logic [CFG_ROWS_W-1:0] rows_sel     = 13'd1;

    // Square-scan state: one line of run lengths from the row above
    logic [RUN_W-1:0] run_line [MAX_COLUMNS];
    logic [RUN_W-1:0] run_left, run_diag, best_size;
    logic [ROW_W-1:0] best_top;
    logic [COL_W-1:0] best_left;
    int               col_pos, row_pos;
    bit               err_seen;

    // 0 acts as 1, anything above the maximum as the maximum
    function automatic int clamp_dim(input int v, input int top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic void clear_grid();
        run_left  = '0;
        run_diag  = '0;
        col_pos   = 0;
        row_pos   = 0;
        best_size = '0;
        best_top  = '0;
        best_left = '0;
        err_seen  = 1'b0;
    endfunction

    // Advance the square scan by one cell; returns 1 with the grid's result on
    // the grid's last cell.
    function automatic bit scan_cell(input cell_t grid_cell, output result_t res);
        int               cols, rows, c, r;
        logic [RUN_W-1:0] up, lft, dg, run;
        bit               last_col, last_cell, blocked;
        cols = clamp_dim(cols_sel, MAX_COLUMNS);
        rows = clamp_dim(rows_sel, MAX_ROWS);
        // a size lowered mid-grid cuts the current row or grid short
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rows) row_pos = rows - 1;
        c = col_pos;
        r = row_pos;
        last_col  = (c == cols - 1);
        last_cell = last_col && (r == rows - 1);

        // equal codes mean obstacle; unknown codes flag the map and block the cell
        blocked = (grid_cell.code == obstacle_sel);
        if (!blocked && grid_cell.code != empty_sel) begin
            err_seen = 1'b1;
            blocked  = 1'b1;
        end
        // line end must sit on the last column; the grid's last cell may omit it
        if (grid_cell.row_end != last_col && !(last_cell && !grid_cell.row_end))
            err_seen = 1'b1;

        up  = (r > 0) ? run_line[c] : '0;
        lft = (c > 0) ? run_left : '0;
        dg  = (r > 0 && c > 0) ? run_diag : '0;
        if (blocked) begin
            run = '0;
        end else begin
            run = (up < lft) ? up : lft;
            if (dg < run) run = dg;
            run = run + 1'b1;
        end
        run_diag    = up;
        run_line[c] = run;
        run_left    = run;

        // strictly larger only: ties keep the earliest top-left corner
        if (run > best_size) begin
            best_size = run;
            best_top  = ROW_W'(r + 1 - run);
            best_left = COL_W'(c + 1 - run);
        end

        res = '0;
        if (last_cell) begin
            if (err_seen) begin
                res.map_error = 1'b1;
            end else begin
                res.side_len    = best_size;
                res.top_row     = best_top;
                res.left_column = best_left;
            end
            clear_grid();
            return 1'b1;
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Sender: holds each cell until accepted, then idles for a random gap
    int send_gap  = 0;
    int send_calm = 0;

    always @(negedge aclk) begin : sender
        cell_t grid_cell;
        if (aresetn && cells_in == cells_out) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cell_queue.size() != 0) begin
                grid_cell = cell_queue.pop_front();
                cells_out++;
                s_tvalid <= 1'b1;
                s_tdata  <= grid_cell.code;
                s_tlast  <= grid_cell.row_end;
                if (send_calm > 0) begin
                    send_calm--;
                end else begin
                    send_gap = pick_gap();
                    if ($urandom_range(39) == 0) send_calm = $urandom_range(20, 120);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and the long hold on request
    int hold_left  = 0;
    int stall_left = 0;
    int take_calm  = 0;

    always @(negedge aclk) begin : receiver
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (take_calm > 0) begin
                take_calm--;
            end else begin
                if ($urandom_range(3) == 0) stall_left = pick_gap();
                if ($urandom_range(39) == 0) take_calm = $urandom_range(20, 120);
            end
        end
    end

    // Monitor: predicts on accepted cells, checks accepted results, and watches
    // for a stuck handshake.
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                idle_cycles = 0;
                cells_in++;
                if (scan_cell(cell_t'{s_tdata, s_tlast}, want))
                    pending_squares.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                idle_cycles     = 0;
                got.side_len    = m_tdata[10:0];
                got.top_row     = m_tdata[22:11];
                got.left_column = m_tdata[32:23];
                got.map_error   = m_tuser;
                if (pending_squares.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: size %0d top %0d left %0d err %0b",
                                 got.side_len, got.top_row, got.left_column,
                                 got.map_error);
                    mismatches++;
                end else begin
                    want = pending_squares.pop_front();
                    if (got.side_len !== want.side_len || got.top_row !== want.top_row
                        || got.left_column !== want.left_column
                        || got.map_error !== want.map_error) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: expected size %0d top %0d left %0d err %0b, %s",
                                     want.side_len, want.top_row, want.left_column,
                                     want.map_error,
                                     $sformatf("got size %0d top %0d left %0d err %0b",
                                               got.side_len, got.top_row,
                                               got.left_column, got.map_error));
                        mismatches++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Wait until every cell is in and every result out, then let the pipe settle
    task automatic drain();
        while (cell_queue.size() != 0 || cells_in != cells_out || pending_squares.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_EMPTY_CODE:    empty_sel    = value[CODE_W-1:0];
            REG_OBSTACLE_CODE: obstacle_sel = value[CODE_W-1:0];
            REG_GRID_COLUMNS:  cols_sel     = value[CFG_COLS_W-1:0];
            default:           rows_sel     = value[CFG_ROWS_W-1:0];
        endcase
    endtask

    task automatic set_grid(input int e_code, input int o_code, input int cols, input int rows);
        drain();
        write_reg(REG_EMPTY_CODE, e_code);
        write_reg(REG_OBSTACLE_CODE, o_code);
        write_reg(REG_GRID_COLUMNS, cols);
        write_reg(REG_GRID_ROWS, rows);
    endtask

    // One grid at the current size: empty_pct sets the share of empty cells,
    // bad_pct the rate of stray codes and (at half rate) flipped line ends.
    task automatic queue_grid(input int empty_pct, input int bad_pct);
        int    cols, rows;
        bit    last_col;
        cell_t grid_cell;
        cols = clamp_dim(cols_sel, MAX_COLUMNS);
        rows = clamp_dim(rows_sel, MAX_ROWS);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                last_col = (c == cols - 1);
                if ($urandom_range(99) < bad_pct) begin
                    do
                        grid_cell.code = CODE_W'($urandom_range(255));
                    while (grid_cell.code == empty_sel || grid_cell.code == obstacle_sel);
                end else if ($urandom_range(99) < empty_pct) begin
                    grid_cell.code = empty_sel;
                end else begin
                    grid_cell.code = obstacle_sel;
                end
                grid_cell.row_end = last_col;
                // the grid's last cell may legally go without a line end
                if (last_col && r == rows - 1 && $urandom_range(1) == 1)
                    grid_cell.row_end = 1'b0;
                if ($urandom_range(199) < bad_pct)
                    grid_cell.row_end = !grid_cell.row_end;
                cell_queue.push_back(grid_cell);
            end
        end
    endtask

    // All obstacles but the final cell: pushes the corner to the far end
    task automatic queue_corner_grid();
        int cols, rows;
        cols = clamp_dim(cols_sel, MAX_COLUMNS);
        rows = clamp_dim(rows_sel, MAX_ROWS);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                cell_queue.push_back(cell_t'{(r == rows - 1 && c == cols - 1) ?
                                             empty_sel : obstacle_sel, c == cols - 1});
    endtask

    initial begin : stimulus
        int e_code, o_code, cols, rows, roll, grids;
        int random_cells, random_grids;
        for (int i = 0; i < MAX_COLUMNS; i++) run_line[i] = '0;
        clear_grid();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, one-cell grids: empty, obstacle without line end, stray code
        cell_queue.push_back(cell_t'{8'd46, 1'b1});
        cell_queue.push_back(cell_t'{8'd111, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b1});

        // 3x2 grid, codes at the extremes: a 2x2 square at the origin
        set_grid(8'h00, 8'hFF, 3, 2);
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b1});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'hFF, 1'b1});
        // same size, line end one column early
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b1});
        cell_queue.push_back(cell_t'{8'h00, 1'b1});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});
        cell_queue.push_back(cell_t'{8'h00, 1'b0});

        // empty and obstacle share a code: everything is an obstacle
        set_grid(8'hA5, 8'hA5, 2, 1);
        cell_queue.push_back(cell_t'{8'hA5, 1'b0});
        cell_queue.push_back(cell_t'{8'hA5, 1'b1});

        // size lowered in the middle of a grid
        set_grid(8'h2E, 8'h6F, 4, 3);
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        cell_queue.push_back(cell_t'{8'h6F, 1'b1});
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        drain();
        write_reg(REG_GRID_COLUMNS, 2);
        write_reg(REG_GRID_ROWS, 2);
        cell_queue.push_back(cell_t'{8'h2E, 1'b0});
        cell_queue.push_back(cell_t'{8'h2E, 1'b1});

        // Sizes written as zero (act as one), codes at the extremes,
        // and a larger all-empty square
        set_grid(8'h2E, 8'h6F, 7, 0);
        queue_corner_grid();
        set_grid(8'hFF, 8'h00, 0, 9);
        queue_corner_grid();
        set_grid(8'h5A, 8'hC3, 12, 12);
        queue_grid(100, 0);

        // Long receiver hold on one-cell grids: the block fills and stalls input
        set_grid(8'd46, 8'd111, 1, 1);
        hold_requests++;
        repeat (40) queue_grid(70, 5);

        // Random phases: fresh settings, then a few grids at that size
        random_cells = 0;
        random_grids = 0;
        while (random_cells < RANDOM_CELLS || random_grids < RANDOM_GRIDS) begin
            e_code = $urandom_range(255);
            case ($urandom_range(9))
                0:       e_code = 0;
                1:       e_code = 255;
                default: ;
            endcase
            o_code = $urandom_range(255);
            if ($urandom_range(14) == 0) o_code = e_code;
            roll = $urandom_range(19);
            if (roll == 0) begin
                cols = $urandom_range(9, 40);
                rows = $urandom_range(1, 4);
            end else if (roll == 1) begin
                cols = $urandom_range(1, 4);
                rows = $urandom_range(9, 30);
            end else begin
                cols = $urandom_range(0, 8);
                rows = $urandom_range(0, 8);
            end
            set_grid(e_code, o_code, cols, rows);
            grids = $urandom_range(1, 4);
            repeat (grids) begin
                // most grids well formed; about one in five is noisy
                queue_grid($urandom_range(50, 100),
                           ($urandom_range(4) == 0) ? $urandom_range(1, 20) : 0);
                random_cells += clamp_dim(cols, MAX_COLUMNS) * clamp_dim(rows, MAX_ROWS);
                random_grids++;
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
